// ===== rtl/core/akf_pkg.sv =====
// Shared types, constants and the update program of the angle/bias Kalman filter.
package akf_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF   = 20;

  localparam int unsigned CFG_W     = 31;
  localparam int unsigned CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_NOISE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_NOISE  = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS_NOISE  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD      = 8'd3;

  localparam logic [CFG_W-1:0] RST_ANGLE_NOISE = 31'd1049;
  localparam logic [CFG_W-1:0] RST_BIAS_NOISE  = 31'd3146;
  localparam logic [CFG_W-1:0] RST_MEAS_NOISE  = 31'd10486;
  localparam logic [CFG_W-1:0] RST_PERIOD      = 31'd2621;

  typedef enum logic [1:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV} op_e;

  typedef enum logic [4:0] {
    R_ANG, R_BIAS, R_P00, R_P01, R_P10, R_P11, R_Z, R_W, R_T, R_Y,
    R_S, R_K0, R_K1, R_INN, R_TMP, R_QA, R_QB, R_RM, R_DT
  } reg_sel_e;

  typedef struct packed {
    op_e      op;
    reg_sel_e src_a;
    reg_sel_e src_b;
    reg_sel_e dst;
  } uop_t;

  localparam int unsigned      PC_W    = 5;
  localparam logic [PC_W-1:0]  LAST_PC = 5'd28;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_PUBLISH} ctrl_state_e;
  typedef enum logic [2:0] {MD_IDLE, MD_MUL, MD_DIV, MD_ROUND, MD_SAT} md_state_e;

  typedef struct packed {
    logic load_in;
    logic issue;
    uop_t uop;
    logic load_out;
  } akf_cmd_t;

  typedef struct packed {
    logic unit_done;
  } akf_sts_t;

  // One item runs through predict and update as this fixed list of operations.
  function automatic uop_t uop_at(input logic [PC_W-1:0] pc);
    uop_t u;
    case (pc)
      5'd0:    u = '{OP_SUB, R_W,    R_BIAS, R_T};
      5'd1:    u = '{OP_MUL, R_DT,   R_T,    R_TMP};
      5'd2:    u = '{OP_ADD, R_ANG,  R_TMP,  R_ANG};
      5'd3:    u = '{OP_MUL, R_DT,   R_P11,  R_T};
      5'd4:    u = '{OP_SUB, R_T,    R_P01,  R_INN};
      5'd5:    u = '{OP_SUB, R_INN,  R_P10,  R_INN};
      5'd6:    u = '{OP_ADD, R_INN,  R_QA,   R_INN};
      5'd7:    u = '{OP_MUL, R_DT,   R_INN,  R_TMP};
      5'd8:    u = '{OP_ADD, R_P00,  R_TMP,  R_P00};
      5'd9:    u = '{OP_SUB, R_P01,  R_T,    R_P01};
      5'd10:   u = '{OP_SUB, R_P10,  R_T,    R_P10};
      5'd11:   u = '{OP_MUL, R_QB,   R_DT,   R_TMP};
      5'd12:   u = '{OP_ADD, R_P11,  R_TMP,  R_P11};
      5'd13:   u = '{OP_SUB, R_Z,    R_ANG,  R_Y};
      5'd14:   u = '{OP_ADD, R_P00,  R_RM,   R_S};
      5'd15:   u = '{OP_DIV, R_P00,  R_S,    R_K0};
      5'd16:   u = '{OP_DIV, R_P10,  R_S,    R_K1};
      5'd17:   u = '{OP_MUL, R_K0,   R_Y,    R_TMP};
      5'd18:   u = '{OP_ADD, R_ANG,  R_TMP,  R_ANG};
      5'd19:   u = '{OP_MUL, R_K1,   R_Y,    R_TMP};
      5'd20:   u = '{OP_ADD, R_BIAS, R_TMP,  R_BIAS};
      5'd21:   u = '{OP_MUL, R_K1,   R_P00,  R_TMP};
      5'd22:   u = '{OP_SUB, R_P10,  R_TMP,  R_P10};
      5'd23:   u = '{OP_MUL, R_K1,   R_P01,  R_TMP};
      5'd24:   u = '{OP_SUB, R_P11,  R_TMP,  R_P11};
      5'd25:   u = '{OP_MUL, R_K0,   R_P00,  R_TMP};
      5'd26:   u = '{OP_SUB, R_P00,  R_TMP,  R_P00};
      5'd27:   u = '{OP_MUL, R_K0,   R_P01,  R_TMP};
      5'd28:   u = '{OP_SUB, R_P01,  R_TMP,  R_P01};
      default: u = '{OP_ADD, R_TMP,  R_TMP,  R_TMP};
    endcase
    return u;
  endfunction

endpackage

// ===== rtl/core/akf_stream_if.sv =====
// Valid/ready channel interfaces for the filter's input and result items.
interface akf_in_if import akf_pkg::*; #(
  parameter int unsigned W = VALUE_WIDTH_DEF
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] measured_angle;
  logic signed [W-1:0] measured_rate;

  modport source (output valid, output measured_angle, output measured_rate, input ready);
  modport sink   (input valid, input measured_angle, input measured_rate, output ready);
endinterface

interface akf_out_if import akf_pkg::*; #(
  parameter int unsigned W = VALUE_WIDTH_DEF
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] estimated_angle;
  logic signed [W-1:0] estimated_bias;

  modport source (output valid, output estimated_angle, output estimated_bias, input ready);
  modport sink   (input valid, input estimated_angle, input estimated_bias, output ready);
endinterface

// ===== rtl/core/akf_muldiv.sv =====
// Shared iterative unit: rounded saturating fixed-point multiply and divide.
module akf_muldiv import akf_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic                   div_i,
  input  logic [VALUE_WIDTH-1:0] a_i,
  input  logic [VALUE_WIDTH-1:0] b_i,
  output logic                   done_o,
  output logic [VALUE_WIDTH-1:0] res_o
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned F  = FRAC_BITS;
  localparam int unsigned NW = W + F;
  localparam int unsigned PW = 2 * W + 1;
  localparam int unsigned MW = ((PW - F) > (NW + 1)) ? (PW - F) : (NW + 1);
  localparam int unsigned CW = $clog2(NW + 1);
  localparam logic [W-1:0]  VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  VMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic [PW-1:0] HALF = PW'(1) << (F - 1);

  md_state_e state_q, state_d;
  logic [CW-1:0]  cnt_q;
  logic           neg_q, zero_q, div_q, done_q;
  logic [W-1:0]   xm_q, res_q;
  logic [2*W-1:0] acc_q;
  logic [NW-1:0]  num_q, quo_q;
  logic [W-1:0]   rem_q;
  logic [MW-1:0]  mag_q;

  logic [W:0]     sum;
  logic [W:0]     r2;
  logic           ge;
  logic           rbit;
  logic [W-1:0]   a_mag, b_mag;

  assign a_mag = a_i[W-1] ? (~a_i + W'(1)) : a_i;
  assign b_mag = b_i[W-1] ? (~b_i + W'(1)) : b_i;

  assign sum  = {1'b0, acc_q[2*W-1:W]} + (acc_q[0] ? {1'b0, xm_q} : '0);
  assign r2   = {rem_q, num_q[NW-1]};
  assign ge   = r2 >= {1'b0, xm_q};
  // Round half away from zero: bump when the remainder is at least half the divisor.
  assign rbit = {rem_q, 1'b0} >= {1'b0, xm_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      MD_IDLE:  if (start_i) state_d = div_i ? MD_DIV : MD_MUL;
      MD_MUL:   if (cnt_q == CW'(1)) state_d = MD_ROUND;
      MD_DIV:   if (cnt_q == CW'(1)) state_d = MD_ROUND;
      MD_ROUND: state_d = MD_SAT;
      MD_SAT:   state_d = MD_IDLE;
      default:  state_d = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MD_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == MD_SAT);
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      MD_IDLE: begin
        if (start_i) begin
          neg_q  <= a_i[W-1] ^ b_i[W-1];
          zero_q <= (b_i == '0);
          div_q  <= div_i;
          rem_q  <= '0;
          if (div_i) begin
            xm_q  <= b_mag;
            num_q <= {a_mag, {F{1'b0}}};
            cnt_q <= CW'(NW);
          end else begin
            xm_q  <= a_mag;
            acc_q <= {{W{1'b0}}, b_mag};
            cnt_q <= CW'(W);
          end
        end
      end
      MD_MUL: begin
        acc_q <= {sum, acc_q[W-1:1]};
        cnt_q <= cnt_q - CW'(1);
      end
      MD_DIV: begin
        rem_q <= ge ? W'(r2 - {1'b0, xm_q}) : W'(r2);
        num_q <= num_q << 1;
        quo_q <= {quo_q[NW-2:0], ge};
        cnt_q <= cnt_q - CW'(1);
      end
      MD_ROUND: begin
        if (div_q) begin
          mag_q <= MW'(quo_q) + MW'(rbit);
        end else begin
          mag_q <= MW'(({1'b0, acc_q} + HALF) >> F);
        end
      end
      MD_SAT: begin
        if (div_q && zero_q) begin
          res_q <= VMAX;
        end else if (neg_q) begin
          res_q <= (mag_q > MW'(VMIN)) ? VMIN : (~W'(mag_q) + W'(1));
        end else begin
          res_q <= (mag_q > MW'(VMAX)) ? VMAX : W'(mag_q);
        end
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

// ===== rtl/core/akf_dp.sv =====
// Datapath: filter state, configuration, operand selection and saturating add/sub.
module akf_dp import akf_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  akf_cmd_t               cmd_i,
  output akf_sts_t               sts_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]       cfg_wdata_i,
  input  logic [VALUE_WIDTH-1:0] z_i,
  input  logic [VALUE_WIDTH-1:0] w_i,
  output logic [VALUE_WIDTH-1:0] est_angle_o,
  output logic [VALUE_WIDTH-1:0] est_bias_o
);

  localparam int unsigned W  = VALUE_WIDTH;
  localparam int unsigned EW = W + CFG_W;
  localparam logic [W-1:0] VMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] VMIN = {1'b1, {(W-1){1'b0}}};

  function automatic logic [W-1:0] cfg_val(input logic [CFG_W-1:0] r);
    logic [EW-1:0] e;
    e = EW'(r);
    return (e > EW'(VMAX)) ? VMAX : W'(e);
  endfunction

  logic [CFG_W-1:0] qa_q, qb_q, rm_q, dt_q;
  logic [W-1:0] ang_q, bias_q, p00_q, p01_q, p10_q, p11_q;
  logic [W-1:0] z_q, w_q, t_q, y_q, s_q, k0_q, k1_q, inn_q, tmp_q;
  logic [W-1:0] est_angle_q, est_bias_q;
  reg_sel_e     dst_q;

  logic [W-1:0] opa, opb, alu_res, unit_res, wr_val;
  logic [W:0]   ext_sum;
  logic         unit_done, alu_op, wr_en;
  reg_sel_e     wr_dst;

  always_comb begin
    case (cmd_i.uop.src_a)
      R_ANG:   opa = ang_q;
      R_BIAS:  opa = bias_q;
      R_P00:   opa = p00_q;
      R_P01:   opa = p01_q;
      R_P10:   opa = p10_q;
      R_P11:   opa = p11_q;
      R_Z:     opa = z_q;
      R_W:     opa = w_q;
      R_T:     opa = t_q;
      R_Y:     opa = y_q;
      R_S:     opa = s_q;
      R_K0:    opa = k0_q;
      R_K1:    opa = k1_q;
      R_INN:   opa = inn_q;
      R_TMP:   opa = tmp_q;
      R_QA:    opa = cfg_val(qa_q);
      R_QB:    opa = cfg_val(qb_q);
      R_RM:    opa = cfg_val(rm_q);
      R_DT:    opa = cfg_val(dt_q);
      default: opa = '0;
    endcase
  end

  always_comb begin
    case (cmd_i.uop.src_b)
      R_ANG:   opb = ang_q;
      R_BIAS:  opb = bias_q;
      R_P00:   opb = p00_q;
      R_P01:   opb = p01_q;
      R_P10:   opb = p10_q;
      R_P11:   opb = p11_q;
      R_Z:     opb = z_q;
      R_W:     opb = w_q;
      R_T:     opb = t_q;
      R_Y:     opb = y_q;
      R_S:     opb = s_q;
      R_K0:    opb = k0_q;
      R_K1:    opb = k1_q;
      R_INN:   opb = inn_q;
      R_TMP:   opb = tmp_q;
      R_QA:    opb = cfg_val(qa_q);
      R_QB:    opb = cfg_val(qb_q);
      R_RM:    opb = cfg_val(rm_q);
      R_DT:    opb = cfg_val(dt_q);
      default: opb = '0;
    endcase
  end

  assign alu_op  = (cmd_i.uop.op == OP_ADD) || (cmd_i.uop.op == OP_SUB);
  assign ext_sum = (cmd_i.uop.op == OP_SUB) ? ({opa[W-1], opa} - {opb[W-1], opb})
                                            : ({opa[W-1], opa} + {opb[W-1], opb});
  assign alu_res = (ext_sum[W] != ext_sum[W-1]) ? (ext_sum[W] ? VMIN : VMAX)
                                                : ext_sum[W-1:0];

  akf_muldiv #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_muldiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.issue && !alu_op),
    .div_i   (cmd_i.uop.op == OP_DIV),
    .a_i     (opa),
    .b_i     (opb),
    .done_o  (unit_done),
    .res_o   (unit_res)
  );

  assign wr_en  = (cmd_i.issue && alu_op) || unit_done;
  assign wr_dst = unit_done ? dst_q : cmd_i.uop.dst;
  assign wr_val = unit_done ? unit_res : alu_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qa_q   <= RST_ANGLE_NOISE;
      qb_q   <= RST_BIAS_NOISE;
      rm_q   <= RST_MEAS_NOISE;
      dt_q   <= RST_PERIOD;
      ang_q  <= '0;
      bias_q <= '0;
      p00_q  <= '0;
      p01_q  <= '0;
      p10_q  <= '0;
      p11_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ANGLE_NOISE: qa_q <= cfg_wdata_i;
          CFG_BIAS_NOISE:  qb_q <= cfg_wdata_i;
          CFG_MEAS_NOISE:  rm_q <= cfg_wdata_i;
          CFG_PERIOD:      dt_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (wr_en) begin
        case (wr_dst)
          R_ANG:  ang_q  <= wr_val;
          R_BIAS: bias_q <= wr_val;
          R_P00:  p00_q  <= wr_val;
          R_P01:  p01_q  <= wr_val;
          R_P10:  p10_q  <= wr_val;
          R_P11:  p11_q  <= wr_val;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      z_q <= z_i;
      w_q <= w_i;
    end
    if (cmd_i.issue) begin
      dst_q <= cmd_i.uop.dst;
    end
    if (cmd_i.load_out) begin
      est_angle_q <= ang_q;
      est_bias_q  <= bias_q;
    end
    if (wr_en) begin
      case (wr_dst)
        R_T:   t_q   <= wr_val;
        R_Y:   y_q   <= wr_val;
        R_S:   s_q   <= wr_val;
        R_K0:  k0_q  <= wr_val;
        R_K1:  k1_q  <= wr_val;
        R_INN: inn_q <= wr_val;
        R_TMP: tmp_q <= wr_val;
        default: ;
      endcase
    end
  end

  assign sts_o.unit_done = unit_done;
  assign est_angle_o     = est_angle_q;
  assign est_bias_o      = est_bias_q;

endmodule

// ===== rtl/core/akf_ctrl.sv =====
// Controller: steps the operation list and runs the input and output handshakes.
module akf_ctrl import akf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output akf_cmd_t cmd_o,
  input  akf_sts_t sts_i
);

  ctrl_state_e     state_q, state_d;
  logic [PC_W-1:0] pc_q;
  logic            out_valid_q;
  uop_t            uop;
  logic            is_alu, advance, publish;

  assign uop     = uop_at(pc_q);
  assign is_alu  = (uop.op == OP_ADD) || (uop.op == OP_SUB);
  assign advance = ((state_q == ST_ISSUE) && is_alu) || ((state_q == ST_WAIT) && sts_i.unit_done);
  assign publish = (state_q == ST_PUBLISH) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (in_valid_i) state_d = ST_ISSUE;
      ST_ISSUE: begin
        if (!is_alu) begin
          state_d = ST_WAIT;
        end else if (pc_q == LAST_PC) begin
          state_d = ST_PUBLISH;
        end else begin
          state_d = ST_ISSUE;
        end
      end
      ST_WAIT: begin
        if (sts_i.unit_done) state_d = (pc_q == LAST_PC) ? ST_PUBLISH : ST_ISSUE;
      end
      ST_PUBLISH: if (publish) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o     = (state_q == ST_IDLE);
    cmd_o.load_in  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.issue    = (state_q == ST_ISSUE);
    cmd_o.uop      = uop;
    cmd_o.load_out = publish;
    out_valid_o    = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.load_in) begin
        pc_q <= '0;
      end else if (advance) begin
        pc_q <= pc_q + PC_W'(1);
      end
      if (publish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/core/angle_bias_kalman_filter.sv =====
// Two-state angle and gyro-bias Kalman filter on signed fixed-point values.
// Each input item (accelerometer angle, gyro rate) gives one result item with the
// updated angle and bias estimates. An item runs through a fixed list of 29
// operations: 17 additions and subtractions done in the datapath, and ten multiplies
// and two divides that share one bit-serial unit.
// One item is worked on at a time; the next one is taken while a result still
// waits in the output register.
module angle_bias_kalman_filter import akf_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
  parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  akf_in_if.sink               in_i,
  akf_out_if.source            out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  akf_cmd_t               cmd;
  akf_sts_t               sts;
  logic [VALUE_WIDTH-1:0] est_angle, est_bias;

  akf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  akf_dp #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .z_i         (in_i.measured_angle),
    .w_i         (in_i.measured_rate),
    .est_angle_o (est_angle),
    .est_bias_o  (est_bias)
  );

  assign out_o.estimated_angle = est_angle;
  assign out_o.estimated_bias  = est_bias;

  // Publishing a new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |-> (!out_o.valid || out_o.ready))
    else $error("result published over an untaken item");

  // The shared unit reports completion for one cycle only.
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.unit_done |=> !sts.unit_done)
    else $error("unit done held longer than one cycle");

  // After an item is taken the block is busy with it.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (!in_i.ready && cmd.issue))
    else $error("item accepted without starting the operation list");

endmodule

// ===== tb/akf_check.sv =====
// Checker for the angle/bias Kalman filter: predicts each result item and compares it.
module akf_check import akf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  akf_in_if                    in_c,
  akf_out_if                   out_c,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  output int                   errors_o,
  output int                   pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic signed [31:0] VMAX = 32'sh7fffffff;
  localparam logic signed [31:0] VMIN = 32'sh80000000;

  typedef struct packed {
    logic signed [31:0] angle;
    logic signed [31:0] bias;
  } estimate_t;

  estimate_t estimates_q[$];

  logic signed [31:0] qa, qb, rm, dt;
  logic signed [31:0] ang, bias, p00, p01, p10, p11;

  function automatic logic signed [31:0] clamp(input longint v);
    if (v > longint'(VMAX)) return VMAX;
    if (v < longint'(VMIN)) return VMIN;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] add_sat(input logic signed [31:0] a, b);
    return clamp(longint'(a) + longint'(b));
  endfunction

  function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a, b);
    return clamp(longint'(a) - longint'(b));
  endfunction

  function automatic logic [63:0] abs64(input logic signed [31:0] v);
    longint l;
    l = v;
    return (l < 0) ? 64'(-l) : 64'(l);
  endfunction

  // Saturates a magnitude with a sign to the 32-bit signed range.
  function automatic logic signed [31:0] from_mag(input logic neg, input logic [127:0] m);
    logic [127:0] lim;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (m > lim) return neg ? VMIN : VMAX;
    return neg ? -m[31:0] : m[31:0];
  endfunction

  function automatic logic signed [31:0] mul_q(input logic signed [31:0] a, b);
    logic [127:0] p;
    p = {64'd0, abs64(a)} * {64'd0, abs64(b)};
    p = (p + 128'd524288) >> 20;
    return from_mag((a < 0) != (b < 0), p);
  endfunction

  function automatic logic signed [31:0] div_q(input logic signed [31:0] n, d);
    logic [127:0] num, den, q, r;
    if (d == 0) return VMAX;
    num = {64'd0, abs64(n)} << 20;
    den = {64'd0, abs64(d)};
    q = num / den;
    r = num % den;
    if (r >= den - r) q = q + 1;
    return from_mag((n < 0) != (d < 0), q);
  endfunction

  task automatic filter_step(input logic signed [31:0] z, w);
    logic signed [31:0] t, inner, y, s, k0, k1, a00, a01;
    t = sub_sat(w, bias);
    ang = add_sat(ang, mul_q(dt, t));
    t = mul_q(dt, p11);
    inner = add_sat(sub_sat(sub_sat(t, p01), p10), qa);
    p00 = add_sat(p00, mul_q(dt, inner));
    p01 = sub_sat(p01, t);
    p10 = sub_sat(p10, t);
    p11 = add_sat(p11, mul_q(qb, dt));
    y = sub_sat(z, ang);
    s = add_sat(p00, rm);
    k0 = div_q(p00, s);
    k1 = div_q(p10, s);
    ang = add_sat(ang, mul_q(k0, y));
    bias = add_sat(bias, mul_q(k1, y));
    a00 = p00;
    a01 = p01;
    p00 = sub_sat(p00, mul_q(k0, a00));
    p01 = sub_sat(p01, mul_q(k0, a01));
    p10 = sub_sat(p10, mul_q(k1, a00));
    p11 = sub_sat(p11, mul_q(k1, a01));
    estimates_q.push_back('{angle: ang, bias: bias});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    estimate_t e;
    if (!rst_ni) begin
      qa <= 32'(RST_ANGLE_NOISE);
      qb <= 32'(RST_BIAS_NOISE);
      rm <= 32'(RST_MEAS_NOISE);
      dt <= 32'(RST_PERIOD);
      {ang, bias, p00, p01, p10, p11} = '0;
      estimates_q.delete();
      errors_o = 0;
    end else begin
      if (out_c.valid && out_c.ready) begin
        if (estimates_q.size() == 0) begin
          $display("%0t: result item with none expected: angle %0d bias %0d", $time,
                   out_c.estimated_angle, out_c.estimated_bias);
          errors_o++;
        end else begin
          e = estimates_q.pop_front();
          if (out_c.estimated_angle !== e.angle) begin
            $display("%0t: angle expected %0d actual %0d", $time, e.angle,
                     out_c.estimated_angle);
            errors_o++;
          end
          if (out_c.estimated_bias !== e.bias) begin
            $display("%0t: bias expected %0d actual %0d", $time, e.bias,
                     out_c.estimated_bias);
            errors_o++;
          end
        end
      end
      if (in_c.valid && in_c.ready) filter_step(in_c.measured_angle, in_c.measured_rate);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ANGLE_NOISE: qa <= {1'b0, cfg_wdata_i};
          CFG_BIAS_NOISE:  qb <= {1'b0, cfg_wdata_i};
          CFG_MEAS_NOISE:  rm <= {1'b0, cfg_wdata_i};
          CFG_PERIOD:      dt <= {1'b0, cfg_wdata_i};
          default: ;
        endcase
      end
    end
    pending_o = estimates_q.size();
  end
endmodule

// ===== tb/testbench.sv =====
// Top of the Kalman filter testbench: clock, reset, configuration and item traffic.
module testbench;
  import akf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 8'd9;
  localparam int CYCLE_LIMIT = 8000000;
  localparam int NUM_PHASES = 8;
  localparam int PHASE_ITEMS = 205;
  localparam int PRESSURE_PHASE = 5;
  localparam logic [CFG_W-1:0] REG_MAX = 31'h7fffffff;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_wdata_i = '0;
  int errors, pending, cycles = 0;
  int phase = 0;
  int send_idle_pct = 0, recv_stall_pct = 0;

  akf_in_if in_c ();
  akf_out_if out_c ();

  initial begin
    in_c.valid = 1'b0;
    in_c.measured_angle = '0;
    in_c.measured_rate = '0;
    out_c.ready = 1'b0;
  end

  angle_bias_kalman_filter dut (
    .clk_i, .rst_ni, .in_i(in_c), .out_o(out_c), .cfg_we_i, .cfg_idx_i, .cfg_wdata_i
  );

  akf_check checker_i (
    .clk_i, .rst_ni, .in_c, .out_c, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .errors_o(errors), .pending_o(pending)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off so the filter backs up.
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 0;
    forever begin
      @(posedge clk_i);
      if (!held && phase == PRESSURE_PHASE) begin
        held = 1;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_c.ready <= 1'b0;
      end else begin
        out_c.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic write_regs(input logic [CFG_W-1:0] qa, qb, rm, dt);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [CFG_W-1:0] val [4];
    idx = '{CFG_ANGLE_NOISE, CFG_BIAS_NOISE, CFG_MEAS_NOISE, CFG_PERIOD};
    val = '{qa, qb, rm, dt};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_idx_i <= idx[i];
      cfg_wdata_i <= val[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_item(input logic [31:0] angle, rate);
    if ($urandom_range(99) < send_idle_pct) begin
      in_c.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_c.valid <= 1'b1;
    in_c.measured_angle <= angle;
    in_c.measured_rate <= rate;
    do @(posedge clk_i); while (!in_c.ready);
  endtask

  // The last item is withdrawn first so that it is not taken a second time.
  task automatic wait_drained();
    in_c.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Angles mostly within about 95 degrees of zero and rates within a few hundred deg/s.
  function automatic logic [31:0] rand_angle();
    if ($urandom_range(9) == 0) return $urandom;
    return 32'($signed($urandom_range(200000000)) - 100000000);
  endfunction

  function automatic logic [31:0] rand_rate();
    if ($urandom_range(9) == 0) return $urandom;
    return 32'($signed($urandom_range(1000000000)) - 500000000);
  endfunction

  initial begin
    logic [31:0] edge_vals [7];
    edge_vals = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff, 32'h1,
                  32'h00100000, 32'hfff00000};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Field extremes at the reset settings.
    for (int i = 0; i < 7; i++) send_item(edge_vals[i], edge_vals[6 - i]);
    send_item(32'h7fffffff, 32'h7fffffff);
    send_item(32'h80000000, 32'h80000000);
    wait_drained();
    // No noise at all: the covariance collapses and the innovation variance
    // reaches zero. An index past the register list is written too.
    write_regs('0, '0, '0, 31'd2621);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_UNUSED_IDX;
    cfg_wdata_i <= REG_MAX;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    for (int i = 0; i < 8; i++) send_item(rand_angle(), rand_rate());
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: write_regs(RST_ANGLE_NOISE, RST_BIAS_NOISE, RST_MEAS_NOISE, RST_PERIOD);
        1: write_regs(REG_MAX, REG_MAX, REG_MAX, REG_MAX);
        2: write_regs('0, '0, '0, '0);
        3: write_regs(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                      CFG_W'($urandom));
        default: write_regs(CFG_W'($urandom_range(20000)), CFG_W'($urandom_range(20000)),
                            CFG_W'($urandom_range(100000)), CFG_W'($urandom_range(20000)));
      endcase
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      phase = p;
      for (int i = 0; i < PHASE_ITEMS; i++) send_item(rand_angle(), rand_rate());
      wait_drained();
    end

    repeat (600) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/akf_pkg.sv
rtl/core/akf_stream_if.sv
rtl/core/akf_muldiv.sv
rtl/core/akf_dp.sv
rtl/core/akf_ctrl.sv
rtl/core/angle_bias_kalman_filter.sv
tb/akf_check.sv
tb/testbench.sv
